@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check of an implication on the rising clock edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Concurrent check that a condition leads to another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ design/swmt_pkg.sv @@
package swmt_pkg;

  localparam int unsigned WindowDepthDefault = 1024;
  localparam int unsigned ValueBinsDefault   = 256;
  localparam int unsigned SampleW = 8;
  localparam int unsigned LenW    = 11;
  localparam int unsigned SumW    = 9;
  localparam int unsigned CountW  = 32;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    BkIdle,
    BkRank,
    BkRead,
    BkUpdate,
    BkOut,
    BkClear
  } bk_state_e;

  // One classified sample as it travels from front to back.
  typedef struct packed {
    logic [SampleW-1:0] sample;
  } swmt_item_t;

endpackage

@@ design/swmt_front.sv @@
// Front: accepts samples and holds them in a two-entry queue for the back end.
module swmt_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [swmt_pkg::SampleW-1:0] sample_i,
  output logic                   q_valid_o,
  output swmt_pkg::swmt_item_t   q_item_o,
  input  logic                   q_pop_i
);

  swmt_pkg::swmt_item_t mem_q [2];
  logic       wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  // Stall only depends on occupancy, never on the incoming valid.
  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ (q_pop_i && q_valid_o);
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i && q_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].sample <= sample_i;
    end
  end

endmodule

@@ design/swmt_back.sv @@
// Back: keeps the ring and histogram, finds the two middle ranks, emits results.
module swmt_back #(
  parameter int unsigned WINDOW_DEPTH = swmt_pkg::WindowDepthDefault,
  parameter int unsigned VALUE_BINS   = swmt_pkg::ValueBinsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [swmt_pkg::LenW-1:0]   cfg_data_i,
  input  logic                        q_valid_i,
  input  swmt_pkg::swmt_item_t        q_item_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        notify_o,
  output logic                        primed_o,
  output logic [swmt_pkg::SumW-1:0]   median_sum_o,
  output logic [swmt_pkg::CountW-1:0] notify_count_o
);

  localparam int unsigned PosW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned BinW = $clog2(VALUE_BINS);
  localparam int unsigned LW   = $clog2(WINDOW_DEPTH + 1) + 1;
  localparam int unsigned RkW  = BinW + 2;
  localparam logic [LW-1:0] DepthL = LW'(WINDOW_DEPTH);
  localparam logic [BinW-1:0] BinMax = BinW'(VALUE_BINS - 1);

  // Ring store and histogram are both memories, read registered.
  logic [BinW-1:0] ring_mem [WINDOW_DEPTH];
  logic [LW-1:0]   hist_mem [VALUE_BINS];

  swmt_pkg::bk_state_e st_q, st_d;
  logic [LW-1:0]   len_q, fill_q;
  logic [PosW-1:0] pos_q;
  logic [BinW-1:0] s_q, old_q, bin_q;
  logic [LW-1:0]   acc_q, hrd_q, k1, k2;
  logic [BinW-1:0] v1_q, v2_q;
  logic            f1_q, f2_q, hvalid_q;
  logic [BinW-1:0] clr_q;
  logic [1:0]      upd_q;
  logic            primed_q, notify_q;
  logic [RkW-1:0]  sum_q;
  logic [swmt_pkg::CountW-1:0] tot_q;
  logic            ovalid_q;
  logic [LW-1:0]   acc_n;
  logic [BinW-1:0] s_sat;
  logic [RkW-1:0]  sum_n;

  assign k1 = LW'((len_q + 1) >> 1);
  assign k2 = LW'((len_q + 2) >> 1);
  assign acc_n = acc_q + hrd_q;
  assign sum_n = RkW'(v1_q) + RkW'(v2_q);
  assign cfg_ready_o = (st_q == swmt_pkg::BkIdle);
  assign q_pop_o = (st_q == swmt_pkg::BkIdle) && q_valid_i && !cfg_valid_i
                   && (!ovalid_q || !out_stall_i);
  assign out_valid_o    = ovalid_q;
  assign notify_o       = notify_q;
  assign primed_o       = primed_q;
  assign median_sum_o   = sum_q[swmt_pkg::SumW-1:0];
  assign notify_count_o = tot_q;

  always_comb begin
    if (32'(q_item_i.sample) > VALUE_BINS - 1) s_sat = BinMax;
    else s_sat = BinW'(q_item_i.sample);
  end

  // Next-state logic of the sequencer.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      swmt_pkg::BkIdle: begin
        if (cfg_valid_i) st_d = swmt_pkg::BkClear;
        else if (q_pop_o) st_d = (fill_q >= len_q) ? swmt_pkg::BkRank
                                                   : swmt_pkg::BkUpdate;
      end
      swmt_pkg::BkRank:   if (hvalid_q && f1_q && f2_q) st_d = swmt_pkg::BkRead;
      swmt_pkg::BkRead:   st_d = swmt_pkg::BkUpdate;
      swmt_pkg::BkUpdate: if (upd_q == 2'd3) st_d = swmt_pkg::BkOut;
      swmt_pkg::BkOut:    st_d = swmt_pkg::BkIdle;
      swmt_pkg::BkClear:  if (clr_q == BinMax) st_d = swmt_pkg::BkIdle;
      default:            st_d = swmt_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= swmt_pkg::BkClear;
      len_q <= LW'(1);
      fill_q <= '0;
      pos_q <= '0;
      clr_q <= '0;
      tot_q <= '0;
      ovalid_q <= 1'b0;
      upd_q <= '0;
      hvalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      unique case (st_q)
        swmt_pkg::BkIdle: begin
          hvalid_q <= 1'b0;
          upd_q <= '0;
          if (cfg_valid_i) begin
            // Clamp the written length to 1..depth and restart the window.
            if (cfg_data_i == '0) len_q <= LW'(1);
            else if (LW'(cfg_data_i) > DepthL) len_q <= DepthL;
            else len_q <= LW'(cfg_data_i);
            fill_q <= '0;
            pos_q <= '0;
            clr_q <= '0;
          end else if (q_pop_o) begin
            if (LW'(pos_q) >= len_q) pos_q <= '0;
          end
        end
        swmt_pkg::BkRank: hvalid_q <= 1'b1;
        swmt_pkg::BkUpdate: upd_q <= upd_q + 2'd1;
        swmt_pkg::BkOut: begin
          ovalid_q <= 1'b1;
          if (primed_q && notify_q && tot_q != swmt_pkg::CountMax) tot_q <= tot_q + 1'b1;
          if (!primed_q) fill_q <= fill_q + 1'b1;
          if (LW'(pos_q) + 1'b1 >= len_q) pos_q <= '0;
          else pos_q <= pos_q + 1'b1;
        end
        swmt_pkg::BkClear: clr_q <= clr_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath: rank scan one bin per cycle, then remove-old and add-new.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      swmt_pkg::BkIdle: begin
        s_q <= s_sat;
        bin_q <= '0;
        acc_q <= '0;
        f1_q <= 1'b0;
        f2_q <= 1'b0;
        // The primed flag is a result field, so it only moves with a new sample.
        if (q_pop_o) primed_q <= (fill_q >= len_q);
        hrd_q <= hist_mem[0];
      end
      swmt_pkg::BkRank: begin
        if (hvalid_q) begin
          acc_q <= acc_n;
          if (!f1_q && (acc_n >= k1 || bin_q == BinMax)) begin
            f1_q <= 1'b1;
            v1_q <= bin_q;
          end
          if (!f2_q && (acc_n >= k2 || bin_q == BinMax)) begin
            f2_q <= 1'b1;
            v2_q <= bin_q;
          end
          bin_q <= bin_q + 1'b1;
          hrd_q <= hist_mem[bin_q + 1'b1];
        end else begin
          hrd_q <= hist_mem[bin_q];
        end
        old_q <= ring_mem[pos_q];
      end
      swmt_pkg::BkRead: begin
        sum_q <= sum_n;
        notify_q <= (RkW'(s_q) >= sum_n);
        hrd_q <= hist_mem[old_q];
      end
      swmt_pkg::BkUpdate: begin
        unique case (upd_q)
          2'd0: if (primed_q && hrd_q != '0) hist_mem[old_q] <= hrd_q - 1'b1;
          2'd1: hrd_q <= hist_mem[s_q];
          2'd2: begin
            hist_mem[s_q] <= hrd_q + 1'b1;
            ring_mem[pos_q] <= s_q;
          end
          default: ;
        endcase
        if (!primed_q) begin
          sum_q <= '0;
          notify_q <= 1'b0;
        end
      end
      swmt_pkg::BkClear: hist_mem[clr_q] <= '0;
      default: ;
    endcase
  end

endmodule

@@ design/sliding_window_median_threshold_unit.sv @@
// Sliding-window median threshold unit.
// Samples enter on the in channel (in_valid_i, in_stall_o, sample_i) into a
// two-entry queue; results leave on the out channel (out_valid_o, out_stall_i)
// with notify, primed, median_sum and the saturating notification count.
// The window length is written on cfg (cfg_valid_i, cfg_ready_o, cfg_data_i)
// while idle; a write restarts the window and clears the histogram.
// While filling, a sample occupies the back end for the pop, four update steps
// and the output step; its result is registered in the output step.
// Once primed, the two middle ranks are found by a scan over the histogram
// memory, one bin per cycle, that stops at the upper middle value; the sample
// then goes through the read, update and output steps, and the back end
// takes no new sample until it is through with this one.
// After reset, and after each length write, a clearing pass over all VALUE_BINS
// bins zeroes the histogram; no sample is taken meanwhile.
// A stalled result holds its register; the back end starts no new sample
// until the held result can move, while the front queue keeps filling and
// raises in_stall_o once it holds two samples.
module sliding_window_median_threshold_unit #(
  parameter int unsigned WINDOW_DEPTH = swmt_pkg::WindowDepthDefault,
  parameter int unsigned VALUE_BINS   = swmt_pkg::ValueBinsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [swmt_pkg::LenW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [swmt_pkg::SampleW-1:0] sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        notify_o,
  output logic                        primed_o,
  output logic [swmt_pkg::SumW-1:0]   median_sum_o,
  output logic [swmt_pkg::CountW-1:0] notify_count_o
);

  logic                 q_valid, q_pop;
  swmt_pkg::swmt_item_t q_item;

  // Front end queue.
  swmt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  // Back end sequencer.
  swmt_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .VALUE_BINS(VALUE_BINS)) u_back (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .notify_o, .primed_o, .median_sum_o, .notify_count_o
  );

endmodule

@@ design/swmt_checker.sv @@
`include "assert_macros.svh"
// Port-level checks of the median threshold unit.
module swmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic        notify_i,
  input logic        primed_i,
  input logic [8:0]  median_sum_i,
  input logic [31:0] notify_count_i
);

  `ASSERT_IMPL(a_notify_primed, clk_i, rst_ni, out_valid_i && notify_i, primed_i, "notify unprimed")
  `ASSERT_IMPL(a_sum_zero, clk_i, rst_ni, out_valid_i && !primed_i, median_sum_i == 9'd0, "sum not zero")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(notify_count_i), "stalled result changed")
  `ASSERT_NEXT(a_count_mono, clk_i, rst_ni, 1'b1, notify_count_i >= $past(notify_count_i), "count decreased")

endmodule

bind sliding_window_median_threshold_unit swmt_checker u_swmt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_valid_o), .out_stall_i(out_stall_i),
  .notify_i(notify_o), .primed_i(primed_o), .median_sum_i(median_sum_o),
  .notify_count_i(notify_count_o)
);
